// File: hw/rtl/cwip_pkg.sv
// shared types, widths and register codes for the camera projection block
package cwip_pkg;

	localparam int D_W   = 33;        // world minus camera, Q.8
	localparam int E_W   = 20;        // matrix entry, Q2.18
	localparam int MP_W  = D_W + E_W; // one matrix product
	localparam int R_W   = 55;        // rotated component, Q.26
	localparam int M_W   = R_W - 1;   // magnitude of a rotated component
	localparam int H_W   = M_W / 2;   // half of the magnitude for the split multiply
	localparam int F_W   = 24;        // focal ratio
	localparam int PP_W  = F_W + H_W; // partial product
	localparam int P_W   = F_W + M_W; // focal times magnitude
	localparam int N_W   = P_W + 1;   // rounding numerator
	localparam int DEN_W = M_W + 1;   // doubled divisor
	localparam int QB    = 42;        // quotient bits worked out by the divider
	localparam int DIV_LAT = QB + 1;
	localparam int C_W   = 23;        // image centre, Q.8

	typedef enum logic [2:0] {
		REG_CAM_POS_X,
		REG_CAM_POS_Y,
		REG_CAM_POS_Z,
		REG_ROT_ROW0,
		REG_ROT_ROW1,
		REG_ROT_ROW2,
		REG_FOCAL_RATIO,
		REG_IMAGE_SIZE
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] ground_height;
	} point_t;

	typedef struct packed {
		logic signed [31:0] image_col;
		logic signed [31:0] image_row;
		logic               depth_zero;
		logic               saturated;
	} pixel_t;

	typedef struct packed {
		logic          ovf;
		logic [QB-1:0] q;
	} div_out_t;

endpackage

// File: hw/rtl/cwip_div.sv
// pipelined restoring divider, one quotient bit per stage
module cwip_div (
	input  logic                      clk,
	input  logic [cwip_pkg::N_W-1:0]   num,
	input  logic [cwip_pkg::DEN_W-1:0] den,
	output cwip_pkg::div_out_t         res
);
	import cwip_pkg::*;

	logic [DEN_W-1:0] rem_s  [0:QB];
	logic [DEN_W-1:0] den_s  [0:QB];
	logic [QB-1:0]    work_s [0:QB];
	logic             ovf_s  [0:QB];

	// quotient of 2^QB or more does not fit, flag it up front
	always_ff @(posedge clk) begin
		ovf_s[0]  <= DEN_W'(num[N_W-1:QB]) >= den;
		rem_s[0]  <= DEN_W'(num[N_W-1:QB]);
		work_s[0] <= num[QB-1:0];
		den_s[0]  <= den;
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DEN_W:0] rem2;
		logic [DEN_W:0] diff;
		logic           ge;
		always_comb begin
			rem2 = {rem_s[i], work_s[i][QB-1]};
			diff = rem2 - {1'b0, den_s[i]};
			ge   = rem2 >= {1'b0, den_s[i]};
		end
		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
			work_s[i+1] <= {work_s[i][QB-2:0], ge};
			den_s[i+1]  <= den_s[i];
			ovf_s[i+1]  <= ovf_s[i];
		end
	end

	assign res.ovf = ovf_s[QB];
	assign res.q   = work_s[QB];

endmodule

// File: hw/rtl/camera_world_to_image_projection_top.sv
// world point to image pixel projection, pipelined top level
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+-------------------------------
//  point    | start, busy, point         | taken when start and not busy
//  pixel    | done, pixel                | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_idx, cfg_data  | written on any edge with cfg_we
//
// a point is taken every cycle; busy is always low
// the pixel strobes once its point has passed stages 1 to 6, the divider and the done register
// the divider has 43 stages: an input stage, then one quotient bit per stage
// reset clears the valid bits and loads the default camera registers
// nothing stalls: the receiver takes every result
module camera_world_to_image_projection_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cwip_pkg::point_t point,
	output logic             done,
	output cwip_pkg::pixel_t pixel,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [59:0]      cfg_data
);
	import cwip_pkg::*;

	localparam int LAT = 6 + DIV_LAT + 1;

	typedef struct packed {
		logic valid;
		logic neg0;
		logic neg1;
		logic dz;
	} side_t;

	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [59:0]        rot_q [0:2];
	logic [F_W-1:0]     focal_q;
	logic [31:0]        image_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q      <= '0;
			cam_y_q      <= '0;
			cam_z_q      <= 32'sd256000;
			rot_q[0]     <= 60'h1 << 58;
			rot_q[1]     <= 60'h1 << 38;
			rot_q[2]     <= 60'h1 << 18;
			focal_q      <= 24'd3938462;
			image_size_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_CAM_POS_X:   cam_x_q      <= cfg_data[31:0];
				REG_CAM_POS_Y:   cam_y_q      <= cfg_data[31:0];
				REG_CAM_POS_Z:   cam_z_q      <= cfg_data[31:0];
				REG_ROT_ROW0:    rot_q[0]     <= cfg_data;
				REG_ROT_ROW1:    rot_q[1]     <= cfg_data;
				REG_ROT_ROW2:    rot_q[2]     <= cfg_data;
				REG_FOCAL_RATIO: focal_q      <= cfg_data[F_W-1:0];
				REG_IMAGE_SIZE:  image_size_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic signed [E_W-1:0] mat [0:2][0:2];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mat[k][0] = rot_q[k][59:40];
			mat[k][1] = rot_q[k][39:20];
			mat[k][2] = rot_q[k][19:0];
		end
	end

	assign busy = 1'b0;

	// stage 1: offset from camera
	logic                  v_s1;
	logic signed [D_W-1:0] d_s1 [0:2];
	always_ff @(posedge clk) begin
		d_s1[0] <= {point.world_x[31], point.world_x} - {cam_x_q[31], cam_x_q};
		d_s1[1] <= {point.world_y[31], point.world_y} - {cam_y_q[31], cam_y_q};
		d_s1[2] <= {point.ground_height[31], point.ground_height} - {cam_z_q[31], cam_z_q};
	end

	// stage 2: matrix products
	logic                   v_s2;
	logic signed [MP_W-1:0] m_s2 [0:2][0:2];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			for (int j = 0; j < 3; j++)
				m_s2[k][j] <= MP_W'(mat[k][j]) * MP_W'(d_s1[j]);
	end

	// stage 3: dot products
	logic                  v_s3;
	logic signed [R_W-1:0] r_s3 [0:2];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			r_s3[k] <= R_W'(m_s2[k][0]) + R_W'(m_s2[k][1]) + R_W'(m_s2[k][2]);
	end

	// stage 4: sign and magnitude
	logic           v_s4;
	logic [M_W-1:0] mag_s4 [0:2];
	logic           neg_s4 [0:1];
	logic           dz_s4;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			mag_s4[k] <= r_s3[k][R_W-1] ? M_W'(-r_s3[k]) : M_W'(r_s3[k]);
		neg_s4[0] <= r_s3[0][R_W-1] ^ r_s3[2][R_W-1];
		neg_s4[1] <= r_s3[1][R_W-1] ^ r_s3[2][R_W-1];
		dz_s4     <= r_s3[2] == '0;
	end

	// stage 5: focal ratio times magnitude, split in two halves
	logic            v_s5;
	logic [PP_W-1:0] pl_s5 [0:1];
	logic [PP_W-1:0] ph_s5 [0:1];
	logic [M_W-1:0]  den_s5;
	logic            neg_s5 [0:1];
	logic            dz_s5;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 2; c++) begin
			pl_s5[c]  <= PP_W'(focal_q) * PP_W'(mag_s4[c][H_W-1:0]);
			ph_s5[c]  <= PP_W'(focal_q) * PP_W'(mag_s4[c][M_W-1:H_W]);
			neg_s5[c] <= neg_s4[c];
		end
		den_s5 <= mag_s4[2];
		dz_s5  <= dz_s4;
	end

	// stage 6: rounding numerator 2p + d over divisor 2d
	logic             v_s6;
	logic [N_W-1:0]   n2_s6 [0:1];
	logic [DEN_W-1:0] den_s6;
	logic             neg_s6 [0:1];
	logic             dz_s6;
	always_ff @(posedge clk) begin
		for (int c = 0; c < 2; c++) begin
			n2_s6[c]  <= {P_W'(pl_s5[c]) + (P_W'(ph_s5[c]) << H_W), 1'b0} + N_W'(den_s5);
			neg_s6[c] <= neg_s5[c];
		end
		den_s6 <= {den_s5, 1'b0};
		dz_s6  <= dz_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	div_out_t q_col, q_row;

	cwip_div u_div_col (.clk(clk), .num(n2_s6[0]), .den(den_s6), .res(q_col));
	cwip_div u_div_row (.clk(clk), .num(n2_s6[1]), .den(den_s6), .res(q_row));

	// side data rides alongside the divider
	side_t side_q [0:DIV_LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				side_q[i] <= '0;
		end else begin
			side_q[0] <= '{valid: v_s6, neg0: neg_s6[0], neg1: neg_s6[1], dz: dz_s6};
			for (int i = 1; i < DIV_LAT; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// centre minus signed quotient, clamped; sat flag in the top bit
	function automatic logic [32:0] finish(logic [C_W-1:0] c, div_out_t dq, logic neg);
		logic signed [44:0] v;
		logic [32:0]        r;
		v = neg ? $signed({22'b0, c}) + $signed({3'b0, dq.q})
		        : $signed({22'b0, c}) - $signed({3'b0, dq.q});
		if (dq.ovf || dq.q > 42'h100_0000_0000)
			r = {1'b1, neg ? 32'h7FFF_FFFF : 32'h8000_0000};
		else if (v > 45'sh7FFF_FFFF)
			r = {1'b1, 32'h7FFF_FFFF};
		else if (v < -45'sh8000_0000)
			r = {1'b1, 32'h8000_0000};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

	side_t       side_f;
	logic [32:0] col_f, row_f;
	always_comb begin
		side_f = side_q[DIV_LAT-1];
		col_f  = finish({image_size_q[31:16], 7'b0}, q_col, side_f.neg0);
		row_f  = finish({image_size_q[15:0], 7'b0}, q_row, side_f.neg1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= side_f.valid;
	end

	always_ff @(posedge clk) begin
		if (side_f.dz) begin
			pixel <= '{image_col: '0, image_row: '0, depth_zero: 1'b1, saturated: 1'b0};
		end else begin
			pixel <= '{image_col: col_f[31:0], image_row: row_f[31:0],
			           depth_zero: 1'b0, saturated: col_f[32] | row_f[32]};
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("item result did not appear at fixed latency");

	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && pixel.depth_zero |->
			pixel.image_col == 0 && pixel.image_row == 0 && !pixel.saturated)
		else $error("zero depth result carries coordinates");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		done && pixel.saturated |->
			pixel.image_col == 32'sh7FFF_FFFF || pixel.image_col == 32'sh8000_0000 ||
			pixel.image_row == 32'sh7FFF_FFFF || pixel.image_row == 32'sh8000_0000)
		else $error("saturated flag without a clipped coordinate");

endmodule
